>>> hdl/b2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared types and constants of the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int MAX_DIGITS  = 10;
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 6;
    localparam int DIGIT_W     = 4;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // divide by ten: q = (v * ceil(2^35 / 10)) >> 35, exact for all 32-bit v
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [IDX_W-1:0]   t_index;

    // one converted value: digits least significant first, and how many
    typedef struct packed {
        t_digit [MAX_DIGITS-1:0] digits;
        t_count                  count;
    } t_run;

endpackage

>>> hdl/b2d_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d stream interfaces
// Valid/ready channels for input values, digit runs and output characters.
// ----------------------------------------------------------------------------
interface b2d_value_if;
    import b2d_pkg::*;
    logic   valid;
    logic   ready;
    t_value value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2d_run_if;
    import b2d_pkg::*;
    logic valid;
    logic ready;
    t_run run;
    modport source (output valid, output run, input ready);
    modport sink   (input valid, input run, output ready);
endinterface

interface b2d_digit_if;
    import b2d_pkg::*;
    logic  valid;
    logic  ready;
    t_char digit_char;
    logic  last_digit;
    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> hdl/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned 32-bit value to decimal ascii digits, most significant first.
// ----------------------------------------------------------------------------
// usage:
//   i_value_if  valid/ready sink, one 32-bit unsigned value per word
//   o_digit_if  valid/ready source, one ascii digit per word, most significant
//               first, leading zeros dropped; last_digit marks the final word
//   a value of zero gives the single character '0'
// conversion of a value of one to ten decimal digits:
//   the converter makes one divide-by-ten step per cycle through a
//   reciprocal multiplier and takes a new value only once the run of the
//   last one is in the queue; the first digit leaves through the registered
//   output and the rest follow one per cycle while the receiver is ready
// a two-entry run queue and a registered output let the converter keep
// working while the receiver stalls; stalls only push back once the queue
// is full. synchronous reset empties the queue and the output register
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
    input  logic i_clk,
    input  logic i_rst_n,
    b2d_value_if.sink    i_value_if,
    b2d_digit_if.source  o_digit_if
);
    import b2d_pkg::*;

    b2d_run_if u_run_wr ();
    b2d_run_if u_run_rd ();

    b2d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_val   (i_value_if),
        .o_run   (u_run_wr)
    );

    b2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (u_run_wr),
        .o_rd    (u_run_rd)
    );

    b2d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (u_run_rd),
        .o_dig   (o_digit_if)
    );

endmodule

>>> hdl/b2d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_front
// Takes a value and peels off its decimal digits, one per cycle, into a run.
// ----------------------------------------------------------------------------
module b2d_front (
    input  logic i_clk,
    input  logic i_rst_n,
    b2d_value_if.sink  i_val,
    b2d_run_if.source  o_run
);
    import b2d_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_PUSH = 3'b100
    } t_front_state;

    t_front_state r_state, n_state;
    t_value       r_val;
    t_run         r_run;

    logic [2*VALUE_W-1:0] w_prod;
    t_value               w_quot;
    t_value               w_rem;
    logic                 w_done;

    assign w_prod = r_val * RECIP_10;
    assign w_quot = VALUE_W'(w_prod >> RECIP_SHIFT);
    assign w_rem  = r_val - ((w_quot << 3) + (w_quot << 1));
    assign w_done = (w_quot == '0) || (r_run.count == CNT_W'(MAX_DIGITS - 1));

    assign i_val.ready = (r_state == ST_IDLE);
    assign o_run.valid = (r_state == ST_PUSH);
    assign o_run.run   = r_run;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_val.valid) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (w_done) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (o_run.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_val.valid) begin
            r_val       <= i_val.value;
            r_run.count <= '0;
        end else if (r_state == ST_CONV) begin
            r_val                                   <= w_quot;
            r_run.digits[r_run.count[IDX_W-1:0]]    <= w_rem[DIGIT_W-1:0];
            r_run.count                             <= r_run.count + 1'b1;
        end
    end

endmodule

>>> hdl/b2d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_queue
// Short queue of converted runs between the converter and the emitter.
// ----------------------------------------------------------------------------
module b2d_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    b2d_run_if.sink    i_wr,
    b2d_run_if.source  o_rd
);
    import b2d_pkg::*;

    t_run                 r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr;
    logic [QPTR_W-1:0]    r_rd_ptr;
    logic [QFILL_W-1:0]   r_fill;
    logic                 w_push;
    logic                 w_pop;

    assign i_wr.ready = (r_fill != QFILL_W'(QUEUE_DEPTH));
    assign o_rd.valid = (r_fill != '0);
    assign o_rd.run   = r_mem[r_rd_ptr];

    assign w_push = i_wr.valid && i_wr.ready;
    assign w_pop  = o_rd.valid && o_rd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_wr.run;
    end

endmodule

>>> hdl/b2d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_back
// Walks a run most significant digit first into a registered ascii output.
// ----------------------------------------------------------------------------
module b2d_back (
    input  logic i_clk,
    input  logic i_rst_n,
    b2d_run_if.sink      i_run,
    b2d_digit_if.source  o_dig
);
    import b2d_pkg::*;

    logic   r_busy;
    t_run   r_run;
    t_index r_idx;
    logic   r_out_valid;
    t_char  r_out_char;
    logic   r_out_last;
    logic   w_slot_free;
    logic   w_emit;

    assign w_slot_free = !r_out_valid || o_dig.ready;
    assign w_emit      = r_busy && w_slot_free;
    assign i_run.ready = !r_busy;

    assign o_dig.valid      = r_out_valid;
    assign o_dig.digit_char = r_out_char;
    assign o_dig.last_digit = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_busy && i_run.valid) begin
                r_busy <= 1'b1;
            end else if (w_emit && r_idx == '0) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_dig.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_run.valid) begin
            r_run <= i_run.run;
            r_idx <= IDX_W'(i_run.run.count - 1'b1);
        end else if (w_emit) begin
            r_idx <= r_idx - 1'b1;
        end
        if (w_emit) begin
            r_out_char <= ASCII_ZERO + CHAR_W'(r_run.digits[r_idx]);
            r_out_last <= (r_idx == '0);
        end
    end

    // the walk index never leaves the loaded run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (CNT_W'(r_idx) < r_run.count))
        else $error("digit index beyond run length");

    // a run taken from the queue always holds at least one digit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && i_run.valid) |-> (i_run.run.count != '0))
        else $error("empty digit run");

    // only decimal characters reach the output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char >= ASCII_ZERO && r_out_char <= ASCII_NINE))
        else $error("output character outside 0 to 9");

    // the final word of a run drops busy on the next edge
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_idx == '0) |=> !r_busy)
        else $error("emitter still busy after last digit");

endmodule

>>> verif/b2d_digit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_digit_checker
// Watches both channels of the converter. Every accepted value is turned into
// its expected decimal characters; each output word is compared with the
// oldest expected character and its last flag.
// ----------------------------------------------------------------------------
module b2d_digit_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    b2d_value_if  i_value_mon,
    b2d_digit_if  i_digit_mon,
    output int    o_errors,
    output int    o_pending
);
    import b2d_pkg::*;

    typedef struct {
        t_char digit_char;
        logic  last_digit;
    } t_due_digit;

    t_due_digit digits_due[$];
    int         mismatch_count = 0;
    int         word_count     = 0;

    assign o_errors = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on word %0d: %s", $realtime, word_count, msg);
        mismatch_count++;
    endtask

    // peel digits least significant first, then queue them most significant first
    task automatic queue_decimal_chars(input t_value value);
        t_digit peeled[MAX_DIGITS];
        t_value rest;
        int     n;
        rest = value;
        n    = 0;
        do begin
            peeled[n] = t_digit'(rest % 10);
            rest      = rest / 10;
            n++;
        end while (rest != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            digits_due.push_back('{digit_char: ASCII_ZERO + t_char'(peeled[k]),
                                   last_digit: (k == 0)});
        end
    endtask

    task automatic check_digit_word(input t_char got_char, input logic got_last);
        t_due_digit due;
        if (digits_due.size() == 0) begin
            report_mismatch($sformatf("no character due, got char=%0d last=%b",
                                      got_char, got_last));
            return;
        end
        due = digits_due.pop_front();
        if (got_char !== due.digit_char)
            report_mismatch($sformatf("char %0d, expected %0d", got_char, due.digit_char));
        if (got_last !== due.last_digit)
            report_mismatch($sformatf("last %b, expected %b", got_last, due.last_digit));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_value_mon.valid && i_value_mon.ready)
                queue_decimal_chars(i_value_mon.value);
            if (i_digit_mon.valid && i_digit_mon.ready) begin
                check_digit_word(i_digit_mon.digit_char, i_digit_mon.last_digit);
                word_count++;
            end
        end
        o_pending <= digits_due.size();
    end

endmodule

>>> verif/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Feeds corner values and random values of every length to the converter,
// with random gaps on the value side and random stalls on the digit side,
// two long digit-side hold-offs to back the block up, and drain pauses. The
// checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii;
    import b2d_pkg::*;

    localparam realtime CLK_PERIOD    = 12.0;
    localparam int      RESET_CYCLES  = 8;
    localparam int      RANDOM_ITEMS  = 350;
    localparam int      MAX_WAIT      = 8;
    localparam int      HOLD_CYCLES   = 250;
    localparam int      SETTLE_CYCLES = 30;
    localparam realtime TIMEOUT_NS    = 4_000_000.0;

    logic i_clk;
    logic i_rst_n;
    int   error_count;
    int   digits_pending;
    bit   send_steady;
    bit   take_steady;
    int   hold_requests;

    b2d_value_if value_ch ();
    b2d_digit_if digit_ch ();

    binary_to_decimal_ascii dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value_if (value_ch),
        .o_digit_if (digit_ch)
    );

    b2d_digit_checker digit_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value_mon (value_ch),
        .i_digit_mon (digit_ch),
        .o_errors    (error_count),
        .o_pending   (digits_pending)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly values of a random decimal length, some with inner zeros, some raw
    function automatic t_value random_value();
        longint unsigned v;
        longint unsigned lo;
        longint unsigned hi;
        int              ndig;
        int              kind;
        kind = $urandom_range(0, 9);
        ndig = $urandom_range(1, MAX_DIGITS);
        if (kind < 2)
            return $urandom();
        if (kind < 4) begin
            v = $urandom_range(1, 9);
            for (int k = 1; k < ndig; k++)
                v = v * 10 + (($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 9));
            return t_value'(v);
        end
        hi = 1;
        for (int k = 0; k < ndig; k++)
            hi = hi * 10;
        lo = (ndig == 1) ? 0 : hi / 10;
        if (hi > 64'h1_0000_0000)
            hi = 64'h1_0000_0000;
        v = lo + ($urandom() % (hi - lo));
        return t_value'(v);
    endfunction

    task automatic offer_value(input t_value v);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            value_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        do @(posedge i_clk); while (!value_ch.ready);
    endtask

    task automatic wait_until_drained();
        value_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (digits_pending != 0) @(posedge i_clk);
    endtask

    // value side and verdict
    initial begin
        t_value corner_values[$] = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101, 32'd105,
            32'd1000, 32'd10000, 32'd100000, 32'd1000000, 32'd10000000,
            32'd100000000, 32'd999999999, 32'd1000000000, 32'd1000000007,
            32'd1234567890, 32'd4000000000, 32'h5555_5555, 32'hAAAA_AAAA,
            32'hFFFF_FFFE, 32'hFFFF_FFFF
        };
        hold_requests  = 0;
        value_ch.valid <= 1'b0;
        value_ch.value <= '0;
        i_rst_n        <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_values[i])
            offer_value(corner_values[i]);
        wait_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                send_steady = ($urandom_range(0, 3) == 0);
            // digit side backs off for a long stretch while values keep coming
            if (n == 90 || n == 260)
                hold_requests++;
            if (n == 170)
                wait_until_drained();
            offer_value(random_value());
        end
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // digit side
    initial begin
        int stall;
        int taken;
        int holds_served;
        taken        = 0;
        holds_served = 0;
        digit_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 60 == 0)
                take_steady = ($urandom_range(0, 3) == 0);
            if (hold_requests != holds_served) begin
                holds_served++;
                digit_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = take_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                digit_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            digit_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!digit_ch.valid);
            taken++;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
